// File: rtl/hbs_pkg.sv
`default_nettype none
package hbs_pkg;

  localparam int Bins      = 4096;
  localparam int CountW    = 32;
  localparam int AddrW     = $clog2(Bins);
  localparam int TotalW    = 48;
  localparam int CfgW      = 13;
  localparam int IdxW      = 16;
  localparam int AmtW      = 32;
  localparam int FreqW     = 32;
  localparam int LimW      = 17;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 88;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_INC   = 2'd2,
    CMD_GET   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic exec_wr;
    logic load_result;
    logic load_clear;
    logic sweep_start;
    logic sweep_step;
  } ctrl_t;

  typedef struct packed {
    logic cmd_is_clear;
    logic sweep_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/histogram_bin_store.sv
// histogram_bin_store: 4096 bins of 32-bit counts plus a 48-bit running total.
// Request channel s_axis: tdata = {amount, bin_index, cmd} (cmd in lowest bits),
//   cmd: clear, set, increase, get. Response channel m_axis:
//   tdata = {total, frequency, ok} (ok in bit 0).
// cfg_we_i/cfg_wdata_i write bin_count; indices at or above min(bin_count, 4096)
//   are rejected (ok 0, frequency 0, total unchanged). A write zeroes all bins.
// Set, increase and get: a read-modify-write through one memory port; the
//   request is captured, its bin is read, then set and increase write it back,
//   and the response is loaded; the next request is taken only after that.
// Clear, reset and a configuration write each run a zeroing sweep over the
//   bin memory, one bin per cycle, during which s_axis_tready is low.
//   A clear responds after its sweep, once the output register is free.
// A response waits in the output register while m_axis_tready is low; the
//   next request is taken meanwhile but holds in execution until the
//   register frees.
`default_nettype none
module histogram_bin_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] cmd, [17:2] bin_index, [49:18] amount, zero fill above
  input  wire logic [hbs_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] ok, [32:1] frequency, [80:33] total, zero fill above
  output logic [hbs_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [hbs_pkg::CfgW-1:0]      cfg_wdata_i
);
  import hbs_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  hbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .cfg_we_i    (cfg_we_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  hbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .req_data_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: rtl/hbs_ctrl.sv
`default_nettype none
module hbs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire logic            cfg_we_i,
  input  wire hbs_pkg::status_t status_i,
  output hbs_pkg::ctrl_t       ctrl_o
);
  import hbs_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   clr_pend_q, clr_pend_d;

  always_comb begin
    state_d     = state_q;
    clr_pend_d  = clr_pend_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        ctrl_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.cmd_is_clear) begin
          ctrl_o.sweep_start = 1'b1;
          clr_pend_d         = 1'b1;
          state_d            = ST_SWEEP;
        end else if (!status_i.out_busy) begin
          ctrl_o.exec_wr     = 1'b1;
          ctrl_o.load_result = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!clr_pend_q) begin
          state_d = ST_IDLE;
        end else if (!status_i.out_busy) begin
          ctrl_o.load_clear = 1'b1;
          clr_pend_d        = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
    if (cfg_we_i) begin
      state_d    = ST_SWEEP;
      clr_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      clr_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_pend_q <= clr_pend_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/hbs_datapath.sv
`default_nettype none
module hbs_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hbs_pkg::ctrl_t               ctrl_i,
  output hbs_pkg::status_t                  status_o,
  input  wire logic [hbs_pkg::InDataW-1:0]  req_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [hbs_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                              rsp_valid_o,
  input  wire logic                         rsp_ready_i,
  output logic [hbs_pkg::OutDataW-1:0]      rsp_data_o
);
  import hbs_pkg::*;

  logic [CountW-1:0] mem [Bins];

  logic [CfgW-1:0]   bin_count_q;
  logic [AddrW-1:0]  cnt_q;
  logic [TotalW-1:0] total_q, total_new;
  logic [1:0]        cmd_q;
  logic [IdxW-1:0]   idx_q;
  logic [AmtW-1:0]   amt_q;
  logic              in_range_q;
  logic [CountW-1:0] rdata_q;
  logic [CountW-1:0] new_bin;
  logic              rsp_valid_q;
  logic [OutDataW-1:0] rsp_data_q;

  logic [1:0]        in_cmd;
  logic [IdxW-1:0]   in_idx;
  logic [AmtW-1:0]   in_amt;
  logic [LimW-1:0]   limit;
  logic              in_range;
  logic              is_set, is_inc;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CountW-1:0] wr_data;
  logic [CountW-1:0] amt_bin;

  assign in_cmd = req_data_i[1:0];
  assign in_idx = req_data_i[IdxW+1:2];
  assign in_amt = req_data_i[AmtW+IdxW+1:IdxW+2];

  assign limit    = ({{(LimW-CfgW){1'b0}}, bin_count_q} > LimW'(Bins)) ?
                    LimW'(Bins) : {{(LimW-CfgW){1'b0}}, bin_count_q};
  assign in_range = {{(LimW-IdxW){1'b0}}, in_idx} < limit;

  assign is_set  = (cmd_q == CMD_SET);
  assign is_inc  = (cmd_q == CMD_INC);
  assign amt_bin = CountW'(amt_q);

  always_comb begin
    new_bin   = rdata_q;
    total_new = total_q;
    if (in_range_q && is_set) begin
      new_bin   = amt_bin;
      total_new = total_q + TotalW'(amt_bin) - TotalW'(rdata_q);
    end else if (in_range_q && is_inc) begin
      new_bin   = rdata_q + amt_bin;
      total_new = total_q + TotalW'(amt_bin);
    end
  end

  assign wr_en   = ctrl_i.sweep_step ||
                   (ctrl_i.exec_wr && in_range_q && (is_set || is_inc));
  assign wr_addr = ctrl_i.sweep_step ? cnt_q : idx_q[AddrW-1:0];
  assign wr_data = ctrl_i.sweep_step ? '0 : new_bin;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q      <= in_cmd;
      idx_q      <= in_idx;
      amt_q      <= in_amt;
      in_range_q <= in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= CfgW'(Bins);
      cnt_q       <= '0;
      total_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        bin_count_q <= cfg_wdata_i;
      end
      if (cfg_we_i || ctrl_i.sweep_start) begin
        cnt_q   <= '0;
        total_q <= '0;
      end else begin
        if (ctrl_i.sweep_step) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (ctrl_i.exec_wr) begin
          total_q <= total_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (ctrl_i.load_result || ctrl_i.load_clear) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_result) begin
      rsp_data_q <= {{(OutDataW-TotalW-FreqW-1){1'b0}}, total_new,
                     in_range_q ? FreqW'(new_bin) : {FreqW{1'b0}}, in_range_q};
    end else if (ctrl_i.load_clear) begin
      rsp_data_q <= {{(OutDataW-1){1'b0}}, 1'b1};
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_data_o  = rsp_data_q;

  assign status_o.cmd_is_clear = (cmd_q == CMD_CLEAR);
  assign status_o.sweep_last   = (cnt_q == AddrW'(Bins - 1));
  assign status_o.out_busy     = rsp_valid_q && !rsp_ready_i;

  // output register is never overwritten while a result is still pending
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.load_result || ctrl_i.load_clear) |-> !(rsp_valid_q && !rsp_ready_i))
    else $error("result loaded over pending result");

  // item writes only touch bins in range
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !ctrl_i.sweep_step) |-> in_range_q)
    else $error("bin write with rejected index");

  // a clear leaves the total at zero
  a_clear_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.sweep_start |=> (total_q == '0))
    else $error("total not cleared");

  // sweep and item execution never overlap
  a_sweep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.sweep_step |-> !(ctrl_i.exec_wr || ctrl_i.rd_en || ctrl_i.capture))
    else $error("sweep overlaps item");

endmodule
`default_nettype wire
